>>> rtl/shs_pkg.sv
package shs_pkg;

  localparam logic [1:0] ACT_CLIMATE = 2'd0;
  localparam logic [1:0] ACT_GAS     = 2'd1;
  localparam logic [1:0] ACT_MOTION  = 2'd2;

  localparam logic [1:0] GEDGE_NONE  = 2'd0;
  localparam logic [1:0] GEDGE_BEGIN = 2'd1;
  localparam logic [1:0] GEDGE_END   = 2'd2;

  localparam logic [1:0] MEV_NONE       = 2'd0;
  localparam logic [1:0] MEV_SUPPRESSED = 2'd1;
  localparam logic [1:0] MEV_INTRUSION  = 2'd2;

  localparam logic [2:0] HEV_NONE            = 3'd0;
  localparam logic [2:0] HEV_CLIMATE_OFFLINE = 3'd1;
  localparam logic [2:0] HEV_CLIMATE_RECOVER = 3'd2;
  localparam logic [2:0] HEV_GAS_FAULT       = 3'd3;
  localparam logic [2:0] HEV_GAS_RECOVER     = 3'd4;

  localparam logic [2:0] REG_BASE_POLL      = 3'd0;
  localparam logic [2:0] REG_BACKOFF_MAX    = 3'd1;
  localparam logic [2:0] REG_RECOVER_SUCC   = 3'd2;
  localparam logic [2:0] REG_OFFLINE_FAILS  = 3'd3;
  localparam logic [2:0] REG_STUCK_STEP     = 3'd4;
  localparam logic [2:0] REG_STUCK_SAMPLES  = 3'd5;
  localparam logic [2:0] REG_RECOVER_SAMPLE = 3'd6;
  localparam logic [2:0] REG_MOTION_CLEAR   = 3'd7;

  localparam logic [15:0] BASE_POLL_RESET   = 16'd2000;
  localparam logic [22:0] BACKOFF_MAX_RESET = 23'd60000;
  localparam logic [7:0]  RECOVER_SUCC_RESET  = 8'd3;
  localparam logic [7:0]  OFFLINE_FAILS_RESET = 8'd3;
  localparam logic [11:0] STUCK_STEP_RESET    = 12'd2;
  localparam logic [7:0]  STUCK_SAMPLES_RESET = 8'd30;
  localparam logic [7:0]  RECOVER_SAMP_RESET  = 8'd3;
  localparam logic [15:0] MOTION_CLEAR_RESET  = 16'd3000;

  localparam logic [15:0] GAS_MAX_LEVEL = 16'd4095;
  localparam logic [7:0]  STREAK_MAX    = 8'hFF;

  typedef struct packed {
    logic [15:0] base_poll_ms;
    logic [22:0] backoff_max_ms;
    logic [7:0]  recover_successes;
    logic [7:0]  offline_fails;
    logic [11:0] stuck_step_limit;
    logic [7:0]  stuck_samples;
    logic [7:0]  recover_samples;
    logic [15:0] motion_clear_ms;
  } cfg_t;

  typedef struct packed {
    logic        disarmed;
    logic        motion_level;
    logic        motion_trigger;
    logic [31:0] now_ms;
    logic        gas_over_limit;
    logic [15:0] gas_level;
    logic [7:0]  humidity;
    logic [7:0]  temperature;
    logic        read_ok;
    logic [1:0]  action;
  } item_t;

  typedef struct packed {
    logic [2:0]  health_event;
    logic [1:0]  motion_event;
    logic        motion_alarm;
    logic [1:0]  gas_edge;
    logic        gas_alarm;
    logic        gas_fault;
    logic [22:0] poll_interval_ms;
    logic [7:0]  last_humidity;
    logic [7:0]  last_temperature;
    logic        climate_online;
  } res_t;

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    sat_inc = (v < STREAK_MAX) ? v + 8'd1 : v;
  endfunction

endpackage

>>> rtl/shs_core.sv
module shs_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  shs_pkg::cfg_t  cfg,
  input  shs_pkg::item_t item,
  output shs_pkg::res_t  res
);

  logic [7:0]  good_streak, good_streak_next;
  logic [7:0]  fail_streak, fail_streak_next;
  logic        was_online, was_online_next;
  logic        online, online_next;
  logic [7:0]  temp_hold, temp_hold_next;
  logic [7:0]  humid_hold, humid_hold_next;
  logic [22:0] interval, interval_next;
  logic [15:0] prev_gas, prev_gas_next;
  logic [7:0]  stuck_count, stuck_count_next;
  logic [7:0]  recover_count, recover_count_next;
  logic        fault_flag, fault_flag_next;
  logic        prev_gas_alarm, prev_gas_alarm_next;
  logic        motion_latch, motion_latch_next;
  logic [31:0] low_since, low_since_next;

  logic [23:0] doubled;
  logic [15:0] diff;
  logic [31:0] elapsed;
  logic        alarm;
  logic [1:0]  gas_edge;
  logic [1:0]  motion_event;
  logic [2:0]  health_event;

  always_comb begin
    good_streak_next    = good_streak;
    fail_streak_next    = fail_streak;
    was_online_next     = was_online;
    online_next         = online;
    temp_hold_next      = temp_hold;
    humid_hold_next     = humid_hold;
    interval_next       = interval;
    prev_gas_next       = prev_gas;
    stuck_count_next    = stuck_count;
    recover_count_next  = recover_count;
    fault_flag_next     = fault_flag;
    prev_gas_alarm_next = prev_gas_alarm;
    motion_latch_next   = motion_latch;
    low_since_next      = low_since;
    gas_edge            = shs_pkg::GEDGE_NONE;
    motion_event        = shs_pkg::MEV_NONE;
    health_event        = shs_pkg::HEV_NONE;
    doubled             = {interval, 1'b0};
    diff = (item.gas_level > prev_gas) ? item.gas_level - prev_gas : prev_gas - item.gas_level;
    alarm   = 1'b0;
    elapsed = 32'd0;

    case (item.action)
      shs_pkg::ACT_CLIMATE: begin
        if (item.read_ok) begin
          fail_streak_next = 8'd0;
          good_streak_next = shs_pkg::sat_inc(good_streak);
          temp_hold_next   = item.temperature;
          humid_hold_next  = item.humidity;
          if (good_streak_next >= cfg.recover_successes) begin
            online_next   = 1'b1;
            interval_next = {7'd0, cfg.base_poll_ms};
          end
        end else begin
          good_streak_next = 8'd0;
          fail_streak_next = shs_pkg::sat_inc(fail_streak);
          if (fail_streak_next >= cfg.offline_fails) begin
            online_next = 1'b0;
            if (was_online) begin
              health_event = shs_pkg::HEV_CLIMATE_OFFLINE;
            end
            if (interval < cfg.backoff_max_ms) begin
              interval_next = (doubled > {1'b0, cfg.backoff_max_ms}) ?
                              cfg.backoff_max_ms : doubled[22:0];
            end
          end
        end
        if (online_next && !was_online) begin
          health_event = shs_pkg::HEV_CLIMATE_RECOVER;
        end
        was_online_next = online_next;
      end
      shs_pkg::ACT_GAS: begin
        if (item.gas_level > shs_pkg::GAS_MAX_LEVEL) begin
          fault_flag_next = 1'b1;
        end else begin
          if (diff <= {4'd0, cfg.stuck_step_limit}) begin
            stuck_count_next = shs_pkg::sat_inc(stuck_count);
          end else begin
            stuck_count_next = 8'd0;
            if (fault_flag) begin
              recover_count_next = shs_pkg::sat_inc(recover_count);
              if (recover_count_next >= cfg.recover_samples) begin
                fault_flag_next    = 1'b0;
                recover_count_next = 8'd0;
                health_event       = shs_pkg::HEV_GAS_RECOVER;
              end
            end
          end
          if (stuck_count_next >= cfg.stuck_samples) begin
            if (!fault_flag_next) begin
              health_event = shs_pkg::HEV_GAS_FAULT;
            end
            fault_flag_next    = 1'b1;
            recover_count_next = 8'd0;
          end
        end
        prev_gas_next = item.gas_level;
        alarm = !fault_flag_next && item.gas_over_limit;
        if (alarm && !prev_gas_alarm) begin
          gas_edge = shs_pkg::GEDGE_BEGIN;
        end else if (!alarm && prev_gas_alarm) begin
          gas_edge = shs_pkg::GEDGE_END;
        end
        prev_gas_alarm_next = alarm;
      end
      shs_pkg::ACT_MOTION: begin
        if (item.motion_trigger) begin
          low_since_next = 32'd0;
          if (item.disarmed) begin
            motion_event = shs_pkg::MEV_SUPPRESSED;
          end else begin
            motion_latch_next = 1'b1;
            motion_event      = shs_pkg::MEV_INTRUSION;
          end
        end
        if (!item.motion_level && motion_latch_next) begin
          if (low_since_next == 32'd0) begin
            low_since_next = item.now_ms;
          end
          elapsed = item.now_ms - low_since_next;
          if (elapsed >= {16'd0, cfg.motion_clear_ms}) begin
            motion_latch_next = 1'b0;
            low_since_next    = 32'd0;
          end
        end
      end
      default: begin
      end
    endcase

    res.climate_online   = online_next;
    res.last_temperature = temp_hold_next;
    res.last_humidity    = humid_hold_next;
    res.poll_interval_ms = interval_next;
    res.gas_fault        = fault_flag_next;
    res.gas_alarm        = prev_gas_alarm_next;
    res.gas_edge         = gas_edge;
    res.motion_alarm     = motion_latch_next;
    res.motion_event     = motion_event;
    res.health_event     = health_event;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      good_streak    <= 8'd0;
      fail_streak    <= 8'd0;
      was_online     <= 1'b1;
      online         <= 1'b0;
      temp_hold      <= 8'd0;
      humid_hold     <= 8'd0;
      interval       <= {7'd0, shs_pkg::BASE_POLL_RESET};
      prev_gas       <= 16'd0;
      stuck_count    <= 8'd0;
      recover_count  <= 8'd0;
      fault_flag     <= 1'b0;
      prev_gas_alarm <= 1'b0;
      motion_latch   <= 1'b0;
      low_since      <= 32'd0;
    end else if (en) begin
      good_streak    <= good_streak_next;
      fail_streak    <= fail_streak_next;
      was_online     <= was_online_next;
      online         <= online_next;
      temp_hold      <= temp_hold_next;
      humid_hold     <= humid_hold_next;
      interval       <= interval_next;
      prev_gas       <= prev_gas_next;
      stuck_count    <= stuck_count_next;
      recover_count  <= recover_count_next;
      fault_flag     <= fault_flag_next;
      prev_gas_alarm <= prev_gas_alarm_next;
      motion_latch   <= motion_latch_next;
      low_since      <= low_since_next;
    end
  end

endmodule

>>> rtl/sensor_health_supervisor_unit.sv
// An accepted input word passes through the input register, then the result register, to the master side.
// Throughput: one word per cycle; the state update sits between the input register and
// the result register, so a new word enters every cycle while the output drains.
// One input word can be held while a finished result waits to be taken.
// Reset (rst, synchronous, active high) restores all configuration registers to their defaults,
// clears the supervision state and empties both pipeline registers.
module sensor_health_supervisor_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // read_ok, temperature[8:1], humidity[16:9], gas_level[32:17], gas_over_limit,
  // now_ms[65:34], motion_trigger, motion_level, disarmed, zero fill [71:69]
  input  logic [71:0] s_axis_tdata,
  // action
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // climate_online, last_temperature[8:1], last_humidity[16:9],
  // poll_interval_ms[39:17], gas_fault, gas_alarm, gas_edge[43:42], motion_alarm,
  // motion_event[46:45], health_event[49:47], zero fill [55:50]
  output logic [55:0] m_axis_tdata
);

  shs_pkg::cfg_t  cfg;
  shs_pkg::item_t in_q;
  shs_pkg::res_t  res;
  shs_pkg::res_t  out_q;
  logic           in_valid;
  logic           out_valid;
  logic           advance;
  logic           cfg_wr;
  logic [2:0]     reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_poll_ms      <= shs_pkg::BASE_POLL_RESET;
      cfg.backoff_max_ms    <= shs_pkg::BACKOFF_MAX_RESET;
      cfg.recover_successes <= shs_pkg::RECOVER_SUCC_RESET;
      cfg.offline_fails     <= shs_pkg::OFFLINE_FAILS_RESET;
      cfg.stuck_step_limit  <= shs_pkg::STUCK_STEP_RESET;
      cfg.stuck_samples     <= shs_pkg::STUCK_SAMPLES_RESET;
      cfg.recover_samples   <= shs_pkg::RECOVER_SAMP_RESET;
      cfg.motion_clear_ms   <= shs_pkg::MOTION_CLEAR_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        shs_pkg::REG_BASE_POLL:      cfg.base_poll_ms      <= pwdata[15:0];
        shs_pkg::REG_BACKOFF_MAX:    cfg.backoff_max_ms    <= pwdata[22:0];
        shs_pkg::REG_RECOVER_SUCC:   cfg.recover_successes <= pwdata[7:0];
        shs_pkg::REG_OFFLINE_FAILS:  cfg.offline_fails     <= pwdata[7:0];
        shs_pkg::REG_STUCK_STEP:     cfg.stuck_step_limit  <= pwdata[11:0];
        shs_pkg::REG_STUCK_SAMPLES:  cfg.stuck_samples     <= pwdata[7:0];
        shs_pkg::REG_RECOVER_SAMPLE: cfg.recover_samples   <= pwdata[7:0];
        shs_pkg::REG_MOTION_CLEAR:   cfg.motion_clear_ms   <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      shs_pkg::REG_BASE_POLL:      prdata = {16'd0, cfg.base_poll_ms};
      shs_pkg::REG_BACKOFF_MAX:    prdata = {9'd0, cfg.backoff_max_ms};
      shs_pkg::REG_RECOVER_SUCC:   prdata = {24'd0, cfg.recover_successes};
      shs_pkg::REG_OFFLINE_FAILS:  prdata = {24'd0, cfg.offline_fails};
      shs_pkg::REG_STUCK_STEP:     prdata = {20'd0, cfg.stuck_step_limit};
      shs_pkg::REG_STUCK_SAMPLES:  prdata = {24'd0, cfg.stuck_samples};
      shs_pkg::REG_RECOVER_SAMPLE: prdata = {24'd0, cfg.recover_samples};
      shs_pkg::REG_MOTION_CLEAR:   prdata = {16'd0, cfg.motion_clear_ms};
      default:                     prdata = 32'd0;
    endcase
  end

  assign advance       = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;

  // hold the input word until the result register frees up
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q <= {s_axis_tdata[68:0], s_axis_tuser};
    end
  end

  shs_core u_core (
    .clk  (clk),
    .rst  (rst),
    .en   (in_valid && advance),
    .cfg  (cfg),
    .item (in_q),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'd0, out_q};

  a_alarm_off_in_fault: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_q.gas_fault && out_q.gas_alarm))
    else $error("gas alarm shown while gas sensor faulted");

  a_edge_matches_alarm: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_q.gas_edge != shs_pkg::GEDGE_NONE |->
      (out_q.gas_edge == shs_pkg::GEDGE_BEGIN) == out_q.gas_alarm)
    else $error("gas edge disagrees with gas alarm level");

  a_health_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_q.health_event <= shs_pkg::HEV_GAS_RECOVER)
    else $error("health event code out of range");

  a_input_held: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_q))
    else $error("pending input word lost during output stall");

  a_result_after_input: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid))
    else $error("result word without an input word");

endmodule

>>> tb/shs_status_checker.sv
module shs_status_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  // read_ok, temperature, humidity, gas_level, gas_over_limit, now_ms,
  // motion_trigger, motion_level, disarmed, zero fill
  input  logic [71:0] s_axis_tdata,
  // action
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // climate_online, last_temperature, last_humidity, poll_interval_ms, gas_fault,
  // gas_alarm, gas_edge, motion_alarm, motion_event, health_event, zero fill
  input  logic [55:0] m_axis_tdata,
  output int          fail_count,
  output int          pending,
  output int          results_checked,
  output int          events_seen
);

  shs_pkg::cfg_t cfg;
  logic [7:0]    good_run;
  logic [7:0]    bad_run;
  logic          prev_online;
  logic          is_online;
  logic [7:0]    temp_kept;
  logic [7:0]    humid_kept;
  logic [22:0]   poll_ms;
  logic [15:0]   last_gas;
  logic [7:0]    flat_count;
  logic [7:0]    moving_count;
  logic          gas_faulted;
  logic          gas_alarm_q;
  logic          motion_latched;
  logic [31:0]   quiet_since;

  shs_pkg::res_t expected_status_q[$];
  shs_pkg::res_t predicted;
  shs_pkg::res_t want;
  shs_pkg::res_t got;

  function automatic logic [7:0] bump(input logic [7:0] v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  task automatic advance_supervisor(input shs_pkg::item_t word, output shs_pkg::res_t r);
    logic [23:0] doubled;
    logic [15:0] delta;
    logic [31:0] elapsed;
    logic        alarm_now;
    r = '0;
    case (word.action)
      shs_pkg::ACT_CLIMATE: begin
        if (word.read_ok) begin
          bad_run = '0;
          good_run = bump(good_run);
          temp_kept = word.temperature;
          humid_kept = word.humidity;
          if (good_run >= cfg.recover_successes) begin
            is_online = 1'b1;
            poll_ms = {7'd0, cfg.base_poll_ms};
          end
        end else begin
          good_run = '0;
          bad_run = bump(bad_run);
          if (bad_run >= cfg.offline_fails) begin
            is_online = 1'b0;
            if (prev_online) r.health_event = shs_pkg::HEV_CLIMATE_OFFLINE;
            if (poll_ms < cfg.backoff_max_ms) begin
              doubled = {poll_ms, 1'b0};
              poll_ms = (doubled > {1'b0, cfg.backoff_max_ms}) ? cfg.backoff_max_ms
                                                               : doubled[22:0];
            end
          end
        end
        if (is_online && !prev_online) r.health_event = shs_pkg::HEV_CLIMATE_RECOVER;
        prev_online = is_online;
      end
      shs_pkg::ACT_GAS: begin
        if (word.gas_level > shs_pkg::GAS_MAX_LEVEL) begin
          gas_faulted = 1'b1;
        end else begin
          delta = (word.gas_level > last_gas) ? word.gas_level - last_gas
                                              : last_gas - word.gas_level;
          if (delta <= {4'd0, cfg.stuck_step_limit}) begin
            flat_count = bump(flat_count);
          end else begin
            flat_count = '0;
            if (gas_faulted) begin
              moving_count = bump(moving_count);
              if (moving_count >= cfg.recover_samples) begin
                gas_faulted = 1'b0;
                moving_count = '0;
                r.health_event = shs_pkg::HEV_GAS_RECOVER;
              end
            end
          end
          if (flat_count >= cfg.stuck_samples) begin
            if (!gas_faulted) r.health_event = shs_pkg::HEV_GAS_FAULT;
            gas_faulted = 1'b1;
            moving_count = '0;
          end
        end
        last_gas = word.gas_level;
        alarm_now = gas_faulted ? 1'b0 : word.gas_over_limit;
        if (alarm_now && !gas_alarm_q) r.gas_edge = shs_pkg::GEDGE_BEGIN;
        else if (!alarm_now && gas_alarm_q) r.gas_edge = shs_pkg::GEDGE_END;
        gas_alarm_q = alarm_now;
      end
      shs_pkg::ACT_MOTION: begin
        if (word.motion_trigger) begin
          quiet_since = '0;
          if (word.disarmed) begin
            r.motion_event = shs_pkg::MEV_SUPPRESSED;
          end else begin
            motion_latched = 1'b1;
            r.motion_event = shs_pkg::MEV_INTRUSION;
          end
        end
        if (!word.motion_level && motion_latched) begin
          if (quiet_since == '0) quiet_since = word.now_ms;
          elapsed = word.now_ms - quiet_since;
          if (elapsed >= {16'd0, cfg.motion_clear_ms}) begin
            motion_latched = 1'b0;
            quiet_since = '0;
          end
        end
      end
      default: begin
      end
    endcase
    r.climate_online = is_online;
    r.last_temperature = temp_kept;
    r.last_humidity = humid_kept;
    r.poll_interval_ms = poll_ms;
    r.gas_fault = gas_faulted;
    r.gas_alarm = gas_alarm_q;
    r.motion_alarm = motion_latched;
  endtask

  task automatic check_field(input string field, input logic [31:0] expected_value,
                             input logic [31:0] actual_value);
    if (actual_value !== expected_value) begin
      $error("%s: expected %0d, got %0d", field, expected_value, actual_value);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cfg.base_poll_ms = shs_pkg::BASE_POLL_RESET;
      cfg.backoff_max_ms = shs_pkg::BACKOFF_MAX_RESET;
      cfg.recover_successes = shs_pkg::RECOVER_SUCC_RESET;
      cfg.offline_fails = shs_pkg::OFFLINE_FAILS_RESET;
      cfg.stuck_step_limit = shs_pkg::STUCK_STEP_RESET;
      cfg.stuck_samples = shs_pkg::STUCK_SAMPLES_RESET;
      cfg.recover_samples = shs_pkg::RECOVER_SAMP_RESET;
      cfg.motion_clear_ms = shs_pkg::MOTION_CLEAR_RESET;
      good_run = '0;
      bad_run = '0;
      prev_online = 1'b1;
      is_online = 1'b0;
      temp_kept = '0;
      humid_kept = '0;
      poll_ms = {7'd0, shs_pkg::BASE_POLL_RESET};
      last_gas = '0;
      flat_count = '0;
      moving_count = '0;
      gas_faulted = 1'b0;
      gas_alarm_q = 1'b0;
      motion_latched = 1'b0;
      quiet_since = '0;
      expected_status_q.delete();
      fail_count = 0;
      results_checked = 0;
      events_seen = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          shs_pkg::REG_BASE_POLL:      cfg.base_poll_ms = pwdata[15:0];
          shs_pkg::REG_BACKOFF_MAX:    cfg.backoff_max_ms = pwdata[22:0];
          shs_pkg::REG_RECOVER_SUCC:   cfg.recover_successes = pwdata[7:0];
          shs_pkg::REG_OFFLINE_FAILS:  cfg.offline_fails = pwdata[7:0];
          shs_pkg::REG_STUCK_STEP:     cfg.stuck_step_limit = pwdata[11:0];
          shs_pkg::REG_STUCK_SAMPLES:  cfg.stuck_samples = pwdata[7:0];
          shs_pkg::REG_RECOVER_SAMPLE: cfg.recover_samples = pwdata[7:0];
          shs_pkg::REG_MOTION_CLEAR:   cfg.motion_clear_ms = pwdata[15:0];
          default: begin
          end
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        advance_supervisor({s_axis_tdata[68:0], s_axis_tuser}, predicted);
        if (predicted.health_event != shs_pkg::HEV_NONE) events_seen++;
        expected_status_q.push_back(predicted);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_status_q.size() == 0) begin
          $error("result word arrived with no expectation pending");
          fail_count++;
        end else begin
          want = expected_status_q.pop_front();
          got = m_axis_tdata[49:0];
          check_field("climate_online", 32'(want.climate_online),
                      32'(got.climate_online));
          check_field("last_temperature", 32'(want.last_temperature),
                      32'(got.last_temperature));
          check_field("last_humidity", 32'(want.last_humidity), 32'(got.last_humidity));
          check_field("poll_interval_ms", 32'(want.poll_interval_ms),
                      32'(got.poll_interval_ms));
          check_field("gas_fault", 32'(want.gas_fault), 32'(got.gas_fault));
          check_field("gas_alarm", 32'(want.gas_alarm), 32'(got.gas_alarm));
          check_field("gas_edge", 32'(want.gas_edge), 32'(got.gas_edge));
          check_field("motion_alarm", 32'(want.motion_alarm), 32'(got.motion_alarm));
          check_field("motion_event", 32'(want.motion_event), 32'(got.motion_event));
          check_field("health_event", 32'(want.health_event), 32'(got.health_event));
          check_field("zero_fill", 32'd0, {26'd0, m_axis_tdata[55:50]});
          results_checked++;
        end
      end
    end
    pending = expected_status_q.size();
  end

endmodule

>>> tb/sensor_health_supervisor_unit_test.sv
module sensor_health_supervisor_unit_test;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int LONG_HOLD       = 300;
  localparam int PHASES          = 8;
  localparam int WORDS_PER_PHASE = 125;
  localparam logic [1:0] ACT_SPARE = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // read_ok, temperature, humidity, gas_level, gas_over_limit, now_ms,
  // motion_trigger, motion_level, disarmed, zero fill
  logic [71:0] s_axis_tdata = '0;
  // action
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // climate_online, last_temperature, last_humidity, poll_interval_ms, gas_fault,
  // gas_alarm, gas_edge, motion_alarm, motion_event, health_event, zero fill
  logic [55:0] m_axis_tdata;

  int fail_count;
  int pending;
  int results_checked;
  int events_seen;

  int cycles = 0;
  int hold_req = 0;
  int holds_done = 0;
  int burst_left = 0;
  bit no_gaps = 1'b0;
  int words_by_action[4] = '{0, 0, 0, 0};

  sensor_health_supervisor_unit dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  shs_status_checker chk (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pready          (pready),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked),
    .events_seen     (events_seen)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("run stopped by cycle limit at %0d cycles", cycles);
      $display("tb: failure");
      $finish;
    end
  end

  // receiver: stall pattern is picked at random and changes over the run
  initial begin
    int mode;
    int mode_left;
    int held;
    mode = 0;
    mode_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != holds_done) begin
        m_axis_tready = 1'b0;
        held = 0;
        while (held < LONG_HOLD) begin
          @(negedge clk);
          held++;
        end
        holds_done++;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      case (mode)
        0: m_axis_tready = 1'b1;
        1: m_axis_tready = 1'($urandom_range(0, 1));
        2: m_axis_tready = ($urandom_range(0, 3) == 0);
        default: m_axis_tready = (mode_left % 3 == 0);
      endcase
    end
  end

  function automatic shs_pkg::item_t climate(input logic ok, input logic [7:0] t,
                                             input logic [7:0] h);
    shs_pkg::item_t w;
    w = '0;
    w.action = shs_pkg::ACT_CLIMATE;
    w.read_ok = ok;
    w.temperature = t;
    w.humidity = h;
    return w;
  endfunction

  function automatic shs_pkg::item_t gas(input logic [15:0] level, input logic over);
    shs_pkg::item_t w;
    w = '0;
    w.action = shs_pkg::ACT_GAS;
    w.gas_level = level;
    w.gas_over_limit = over;
    return w;
  endfunction

  function automatic shs_pkg::item_t motion(input logic trig, input logic lvl,
                                            input logic dis, input logic [31:0] now);
    shs_pkg::item_t w;
    w = '0;
    w.action = shs_pkg::ACT_MOTION;
    w.motion_trigger = trig;
    w.motion_level = lvl;
    w.disarmed = dis;
    w.now_ms = now;
    return w;
  endfunction

  task automatic send_word(input shs_pkg::item_t word);
    s_axis_tdata = {3'b000, word[70:2]};
    s_axis_tuser = word.action;
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    words_by_action[word.action]++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      if (!no_gaps) begin
        s_axis_tvalid = 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
  endtask

  task automatic wait_idle();
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {index, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  initial begin
    shs_pkg::item_t word;
    shs_pkg::cfg_t  setting;
    logic [95:0]    noise;
    logic [31:0]    junk_bits;
    logic [15:0]    gas_walk;
    logic [31:0]    clock_ms;
    bit             climate_good;
    bit             gas_flat;
    int             pick;
    int             offset;
    int             lv;

    gas_walk = '0;
    clock_ms = '0;
    climate_good = 1'b1;
    gas_flat = 1'b1;
    setting.base_poll_ms = shs_pkg::BASE_POLL_RESET;
    setting.backoff_max_ms = shs_pkg::BACKOFF_MAX_RESET;
    setting.recover_successes = shs_pkg::RECOVER_SUCC_RESET;
    setting.offline_fails = shs_pkg::OFFLINE_FAILS_RESET;
    setting.stuck_step_limit = shs_pkg::STUCK_STEP_RESET;
    setting.stuck_samples = shs_pkg::STUCK_SAMPLES_RESET;
    setting.recover_samples = shs_pkg::RECOVER_SAMP_RESET;
    setting.motion_clear_ms = shs_pkg::MOTION_CLEAR_RESET;

    repeat (8) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // directed words on reset settings
    send_word(climate(1'b0, 8'h12, 8'h34));
    send_word(climate(1'b0, 8'h12, 8'h34));
    send_word(climate(1'b0, 8'h12, 8'h34));
    send_word(climate(1'b0, 8'h56, 8'h78));
    send_word(climate(1'b1, 8'hFF, 8'h00));
    send_word(climate(1'b1, 8'h00, 8'hFF));
    send_word(climate(1'b1, 8'hFF, 8'hFF));
    send_word(climate(1'b0, 8'h00, 8'h00));
    send_word(gas(16'hFFFF, 1'b1));
    send_word(gas(16'd4095, 1'b1));
    send_word(gas(16'd0, 1'b1));
    send_word(gas(16'd4000, 1'b1));
    send_word(gas(16'd4001, 1'b0));
    send_word(gas(16'd4096, 1'b0));
    send_word(shs_pkg::item_t'('1));
    send_word(motion(1'b1, 1'b1, 1'b1, 32'd100));
    send_word(motion(1'b1, 1'b1, 1'b0, 32'd100));
    send_word(motion(1'b0, 1'b0, 1'b0, 32'd0));
    send_word(motion(1'b0, 1'b0, 1'b0, 32'd5));
    send_word(motion(1'b0, 1'b0, 1'b0, 32'd3004));
    send_word(motion(1'b0, 1'b0, 1'b0, 32'd3005));
    send_word(motion(1'b1, 1'b0, 1'b0, 32'hFFFF_FFFF));
    send_word(motion(1'b0, 1'b0, 1'b0, 32'd2998));
    send_word(motion(1'b0, 1'b0, 1'b0, 32'd2999));
    send_word(climate(1'b1, 8'hA5, 8'h5A));

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      case (phase)
        1: setting = '{16'd1, 23'd1, 8'd1, 8'd1, 12'd0, 8'd1, 8'd1, 16'd0};
        3: setting = '{16'd65535, 23'd4194304, 8'd255, 8'd255, 12'd4095, 8'd255, 8'd255,
                       16'd65535};
        4: setting = '{16'd0, 23'd100, 8'd0, 8'd0, 12'd0, 8'd0, 8'd0, 16'd0};
        default: begin
          setting.base_poll_ms = 16'($urandom_range(1, 3000));
          setting.backoff_max_ms = ($urandom_range(0, 3) == 0) ? 23'd4194304
                                   : 23'($urandom_range(1, 100000));
          setting.recover_successes = 8'($urandom_range(1, 5));
          setting.offline_fails = 8'($urandom_range(1, 5));
          setting.stuck_step_limit = 12'($urandom_range(0, 30));
          setting.stuck_samples = 8'($urandom_range(1, 10));
          setting.recover_samples = 8'($urandom_range(1, 5));
          setting.motion_clear_ms = 16'($urandom_range(0, 5000));
        end
      endcase
      // unused upper data bits carry junk in some phases
      junk_bits = (phase == 5 || phase == 7) ? $urandom : 32'd0;
      write_reg(shs_pkg::REG_BASE_POLL, {junk_bits[31:16], setting.base_poll_ms});
      write_reg(shs_pkg::REG_BACKOFF_MAX, {junk_bits[31:23], setting.backoff_max_ms});
      write_reg(shs_pkg::REG_RECOVER_SUCC, {junk_bits[31:8], setting.recover_successes});
      write_reg(shs_pkg::REG_OFFLINE_FAILS, {junk_bits[31:8], setting.offline_fails});
      write_reg(shs_pkg::REG_STUCK_STEP, {junk_bits[31:12], setting.stuck_step_limit});
      write_reg(shs_pkg::REG_STUCK_SAMPLES, {junk_bits[31:8], setting.stuck_samples});
      write_reg(shs_pkg::REG_RECOVER_SAMPLE, {junk_bits[31:8], setting.recover_samples});
      write_reg(shs_pkg::REG_MOTION_CLEAR, {junk_bits[31:16], setting.motion_clear_ms});

      no_gaps = (phase == 2 || phase == 6);
      if (phase == 2) hold_req++;

      repeat (WORDS_PER_PHASE) begin
        noise = {$urandom, $urandom, $urandom};
        word = noise[70:0];
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
          word.action = ACT_SPARE;
        end else if (pick < 40) begin
          word.action = shs_pkg::ACT_CLIMATE;
          if ($urandom_range(0, 5) == 0) climate_good = !climate_good;
          word.read_ok = climate_good;
        end else if (pick < 75) begin
          word.action = shs_pkg::ACT_GAS;
          if ($urandom_range(0, 15) == 0) gas_flat = !gas_flat;
          case ($urandom_range(0, 29))
            0: word.gas_level = 16'($urandom_range(4096, 65535));
            1: word.gas_level = noise[95:80];
            default: begin
              if (gas_flat) begin
                offset = $urandom_range(0, setting.stuck_step_limit);
                lv = $urandom_range(0, 1) ? int'(gas_walk) + offset : int'(gas_walk) - offset;
                if (lv < 0) lv = 0;
                if (lv > 4095) lv = 4095;
                word.gas_level = 16'(lv);
              end else begin
                word.gas_level = 16'($urandom_range(0, 4095));
              end
            end
          endcase
          if (word.gas_level <= shs_pkg::GAS_MAX_LEVEL) gas_walk = word.gas_level;
        end else begin
          word.action = shs_pkg::ACT_MOTION;
          case ($urandom_range(0, 19))
            0: clock_ms = '0;
            1: clock_ms = $urandom;
            2: clock_ms = clock_ms + {16'd0, setting.motion_clear_ms};
            3: clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 100);
            default: clock_ms = clock_ms + $urandom_range(0, setting.motion_clear_ms / 2 + 20);
          endcase
          word.now_ms = clock_ms;
          word.motion_trigger = ($urandom_range(0, 3) == 0);
          word.motion_level = ($urandom_range(0, 3) == 0);
          word.disarmed = ($urandom_range(0, 2) == 0);
        end
        send_word(word);
      end
    end

    wait_idle();
    $display("run covered %0d words: %0d climate, %0d gas, %0d motion, %0d unused action",
             words_by_action[0] + words_by_action[1] + words_by_action[2] + words_by_action[3],
             words_by_action[0], words_by_action[1], words_by_action[2], words_by_action[3]);
    $display("%0d register settings, one long output hold, %0d results compared, %0d health events",
             PHASES + 1, results_checked, events_seen);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/shs_pkg.sv
rtl/shs_core.sv
rtl/sensor_health_supervisor_unit.sv
tb/shs_status_checker.sv
tb/sensor_health_supervisor_unit_test.sv
